### rtl/core/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// fcsg_pkg - shared types and constants
// Register offsets, channel helper functions and the mixer status bundle
// used by the channel engine, the filter unit and the top level.
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam int CYC_W      = 9;
  localparam int MAX_TICK   = 256;
  localparam int SEQ_PERIOD = 8192;
  localparam int SEQ_W      = $clog2(SEQ_PERIOD);
  localparam int RATE_W     = 17;
  localparam int RATE_RESET = 48000;
  localparam int CLK_LOG2   = 22;               // 4194304 Hz input clock
  localparam int ACC_W      = CLK_LOG2 + 4;
  localparam int PT_W       = 22;

  localparam logic [23:0] GAIN_INT  = 24'd7689;     // 3690988 / 480, integer part
  localparam logic [23:0] GAIN_FRAC = 24'd268;      // remainder of that division
  localparam logic [23:0] RECIP_15  = 24'd279621;   // ceil(2^22 / 15)
  localparam logic [23:0] HP_COEF   = 24'd16710107;

  localparam logic [5:0] ADDR_REG_LO = 6'h10;
  localparam logic [5:0] ADDR_REG_HI = 6'h25;
  localparam logic [5:0] ADDR_POWER  = 6'h26;
  localparam logic [5:0] ADDR_WAVE   = 6'h30;

  localparam logic [4:0] IX_NR10 = 5'h00;
  localparam logic [4:0] IX_NR11 = 5'h01;
  localparam logic [4:0] IX_NR12 = 5'h02;
  localparam logic [4:0] IX_NR13 = 5'h03;
  localparam logic [4:0] IX_NR14 = 5'h04;
  localparam logic [4:0] IX_NR21 = 5'h06;
  localparam logic [4:0] IX_NR22 = 5'h07;
  localparam logic [4:0] IX_NR23 = 5'h08;
  localparam logic [4:0] IX_NR24 = 5'h09;
  localparam logic [4:0] IX_NR30 = 5'h0A;
  localparam logic [4:0] IX_NR31 = 5'h0B;
  localparam logic [4:0] IX_NR32 = 5'h0C;
  localparam logic [4:0] IX_NR33 = 5'h0D;
  localparam logic [4:0] IX_NR34 = 5'h0E;
  localparam logic [4:0] IX_NR41 = 5'h10;
  localparam logic [4:0] IX_NR42 = 5'h11;
  localparam logic [4:0] IX_NR43 = 5'h12;
  localparam logic [4:0] IX_NR44 = 5'h13;
  localparam logic [4:0] IX_NR50 = 5'h14;
  localparam logic [4:0] IX_NR51 = 5'h15;

  localparam logic [14:0] LFSR_SEED = 15'h7FFF;

  localparam logic [7:0] DUTY_ROWS [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};
  localparam logic [6:0] NOISE_DIV [8] = '{7'd8, 7'd16, 7'd32, 7'd48,
                                           7'd64, 7'd80, 7'd96, 7'd112};

  typedef struct packed {
    logic              power;
    logic signed [8:0] lsum;
    logic signed [8:0] rsum;
    logic [3:0]        lvol;
    logic [3:0]        rvol;
  } mix_t;

  function automatic logic [10:0] reg_freq(input logic [7:0] lo, input logic [7:0] hi);
    reg_freq = {hi[2:0], lo};
  endfunction

  function automatic logic [PT_W-1:0] sq_period(input logic [10:0] f);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, f};
    sq_period = {{(PT_W-14){1'b0}}, d, 2'b00};
  endfunction

  function automatic logic [PT_W-1:0] wave_period(input logic [10:0] f);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, f};
    wave_period = {{(PT_W-13){1'b0}}, d, 1'b0};
  endfunction

  function automatic logic [PT_W-1:0] noise_period(input logic [7:0] r);
    noise_period = {{(PT_W-7){1'b0}}, NOISE_DIV[r[2:0]]} << r[7:4];
  endfunction

  // bit 11 set means overflow past 2047
  function automatic logic [11:0] sweep_calc(input logic [10:0] sh, input logic [2:0] shift,
                                             input logic neg);
    logic [11:0] d;
    d = {1'b0, sh >> shift};
    sweep_calc = neg ? ({1'b0, sh} - d) : ({1'b0, sh} + d);
  endfunction

endpackage

### rtl/core/fcsg_chan.sv
// ----------------------------------------------------------------------------
// fcsg_chan - channel engine
// Register page, power, frame sequencer, length, envelope and sweep logic,
// and a shared period-timer stepper that walks the four channels one
// wrap per cycle. Presents the panned channel sums to the mixer.
// ----------------------------------------------------------------------------
module fcsg_chan import fcsg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_i,
  input  logic [5:0]       addr_i,
  input  logic [7:0]       data_i,
  input  logic             tick_i,
  input  logic [CYC_W-1:0] cyc_i,
  output logic             busy_o,
  output mix_t             mix_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_TIMER = 2'b10
  } st_t;

  st_t              st_r, st_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic [CYC_W-1:0] rem_r, rem_nxt;

  logic [7:0]       raw_r   [22];
  logic [7:0]       raw_nxt [22];
  logic [7:0]       wave_r   [16];
  logic [7:0]       wave_nxt [16];
  logic             power_r, power_nxt;
  logic [SEQ_W-1:0] seq_cnt_r, seq_cnt_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [3:0]       on_r, on_nxt;
  logic [3:0]       dac_r, dac_nxt;
  logic [3:0]       armed_r, armed_nxt;
  logic [8:0]       len_r   [4];
  logic [8:0]       len_nxt [4];
  logic [3:0]       env_vol_r   [3];
  logic [3:0]       env_vol_nxt [3];
  logic [2:0]       env_per_r   [3];
  logic [2:0]       env_per_nxt [3];
  logic [3:0]       env_tmr_r   [3];
  logic [3:0]       env_tmr_nxt [3];
  logic [2:0]       env_rise_r, env_rise_nxt;
  logic [PT_W-1:0]  pt_r   [4];
  logic [PT_W-1:0]  pt_nxt [4];
  logic [4:0]       pos_r   [3];
  logic [4:0]       pos_nxt [3];
  logic [10:0]      freq_r   [3];
  logic [10:0]      freq_nxt [3];
  logic [10:0]      sw_sh_r, sw_sh_nxt;
  logic [3:0]       sw_tmr_r, sw_tmr_nxt;
  logic [2:0]       sw_per_r, sw_per_nxt;
  logic [2:0]       sw_shift_r, sw_shift_nxt;
  logic             sw_neg_r, sw_neg_nxt;
  logic             sw_act_r, sw_act_nxt;
  logic [14:0]      lfsr_r, lfsr_nxt;

  logic [4:0]       idx;
  logic             trig_sq, trig_wave, trig_noise, sc;
  logic [1:0]       sq_ix;
  logic [10:0]      f_sq;
  logic [7:0]       env_reg, sw_reg;
  logic [11:0]      swc;
  logic [SEQ_W:0]   cnt_sum;
  logic [PT_W-1:0]  per_c, pte;
  logic             fb;

  assign idx = addr_i[4:0] - ADDR_REG_LO[4:0];

  always_comb begin
    st_nxt = st_r; ch_nxt = ch_r; cyc_nxt = cyc_r; rem_nxt = rem_r;
    raw_nxt = raw_r; wave_nxt = wave_r; power_nxt = power_r;
    seq_cnt_nxt = seq_cnt_r; step_nxt = step_r;
    on_nxt = on_r; dac_nxt = dac_r; armed_nxt = armed_r; len_nxt = len_r;
    env_vol_nxt = env_vol_r; env_per_nxt = env_per_r; env_tmr_nxt = env_tmr_r;
    env_rise_nxt = env_rise_r; pt_nxt = pt_r; pos_nxt = pos_r; freq_nxt = freq_r;
    sw_sh_nxt = sw_sh_r; sw_tmr_nxt = sw_tmr_r; sw_per_nxt = sw_per_r;
    sw_shift_nxt = sw_shift_r; sw_neg_nxt = sw_neg_r; sw_act_nxt = sw_act_r;
    lfsr_nxt = lfsr_r;
    trig_sq = 1'b0; trig_wave = 1'b0; trig_noise = 1'b0; sc = 1'b0;
    sq_ix = 2'd0; f_sq = '0; env_reg = '0; sw_reg = '0; swc = '0;
    cnt_sum = '0; per_c = '0; pte = '0; fb = 1'b0;

    if (wr_i) begin
      if (addr_i == ADDR_POWER) begin
        if (data_i[7] != power_r) begin
          on_nxt = '0; dac_nxt = '0; armed_nxt = '0;
          len_nxt = '{default: '0}; pt_nxt = '{default: '0};
          env_vol_nxt = '{default: '0}; env_per_nxt = '{default: '0};
          env_tmr_nxt = '{default: '0}; env_rise_nxt = '0;
          pos_nxt = '{default: '0}; freq_nxt = '{default: '0};
          sw_sh_nxt = '0; sw_tmr_nxt = '0; sw_per_nxt = '0; sw_shift_nxt = '0;
          sw_neg_nxt = 1'b0; sw_act_nxt = 1'b0;
          lfsr_nxt = LFSR_SEED; seq_cnt_nxt = '0; step_nxt = '0;
          power_nxt = data_i[7];
          if (data_i[7]) begin
            // rebuild from the register page
            len_nxt[0] = 9'd64 - {3'b0, raw_r[IX_NR11][5:0]};
            len_nxt[1] = 9'd64 - {3'b0, raw_r[IX_NR21][5:0]};
            len_nxt[2] = 9'd256 - {1'b0, raw_r[IX_NR31]};
            len_nxt[3] = 9'd64 - {3'b0, raw_r[IX_NR41][5:0]};
            armed_nxt = {raw_r[IX_NR44][6], raw_r[IX_NR34][6],
                         raw_r[IX_NR24][6], raw_r[IX_NR14][6]};
            freq_nxt[0] = reg_freq(raw_r[IX_NR13], raw_r[IX_NR14]);
            freq_nxt[1] = reg_freq(raw_r[IX_NR23], raw_r[IX_NR24]);
            freq_nxt[2] = reg_freq(raw_r[IX_NR33], raw_r[IX_NR34]);
            dac_nxt = {|raw_r[IX_NR42][7:3], raw_r[IX_NR30][7],
                       |raw_r[IX_NR22][7:3], |raw_r[IX_NR12][7:3]};
          end
        end
      end else if (addr_i >= ADDR_WAVE) begin
        wave_nxt[addr_i[3:0]] = data_i;
      end else if (addr_i >= ADDR_REG_LO && addr_i <= ADDR_REG_HI) begin
        raw_nxt[idx] = data_i;
        if (power_r) begin
          unique case (idx)
            IX_NR10: begin
              sw_per_nxt = data_i[6:4]; sw_shift_nxt = data_i[2:0]; sw_neg_nxt = data_i[3];
            end
            IX_NR11: len_nxt[0] = 9'd64 - {3'b0, data_i[5:0]};
            IX_NR21: len_nxt[1] = 9'd64 - {3'b0, data_i[5:0]};
            IX_NR12: begin
              dac_nxt[0] = |data_i[7:3];
              if (!dac_nxt[0]) on_nxt[0] = 1'b0;
            end
            IX_NR22: begin
              dac_nxt[1] = |data_i[7:3];
              if (!dac_nxt[1]) on_nxt[1] = 1'b0;
            end
            IX_NR13: freq_nxt[0] = reg_freq(raw_nxt[IX_NR13], raw_nxt[IX_NR14]);
            IX_NR23: freq_nxt[1] = reg_freq(raw_nxt[IX_NR23], raw_nxt[IX_NR24]);
            IX_NR14: begin
              armed_nxt[0] = data_i[6];
              freq_nxt[0] = reg_freq(raw_nxt[IX_NR13], raw_nxt[IX_NR14]);
              trig_sq = data_i[7]; sc = 1'b0;
            end
            IX_NR24: begin
              armed_nxt[1] = data_i[6];
              freq_nxt[1] = reg_freq(raw_nxt[IX_NR23], raw_nxt[IX_NR24]);
              trig_sq = data_i[7]; sc = 1'b1;
            end
            IX_NR30: begin
              dac_nxt[2] = data_i[7];
              if (!dac_nxt[2]) on_nxt[2] = 1'b0;
            end
            IX_NR31: len_nxt[2] = 9'd256 - {1'b0, data_i};
            IX_NR33: freq_nxt[2] = reg_freq(raw_nxt[IX_NR33], raw_nxt[IX_NR34]);
            IX_NR34: begin
              armed_nxt[2] = data_i[6];
              freq_nxt[2] = reg_freq(raw_nxt[IX_NR33], raw_nxt[IX_NR34]);
              trig_wave = data_i[7];
            end
            IX_NR41: len_nxt[3] = 9'd64 - {3'b0, data_i[5:0]};
            IX_NR42: begin
              dac_nxt[3] = |data_i[7:3];
              if (!dac_nxt[3]) on_nxt[3] = 1'b0;
            end
            IX_NR44: begin
              armed_nxt[3] = data_i[6];
              trig_noise = data_i[7];
            end
            default: ;
          endcase
        end
      end
    end

    if (trig_sq) begin
      sq_ix = {1'b0, sc};
      f_sq = sc ? reg_freq(raw_nxt[IX_NR23], raw_nxt[IX_NR24])
                : reg_freq(raw_nxt[IX_NR13], raw_nxt[IX_NR14]);
      env_reg = sc ? raw_nxt[IX_NR22] : raw_nxt[IX_NR12];
      freq_nxt[sq_ix] = f_sq;
      if (len_nxt[sq_ix] == 9'd0) len_nxt[sq_ix] = 9'd64;
      pt_nxt[sq_ix] = sq_period(f_sq);
      pos_nxt[sq_ix] = '0;
      on_nxt[sq_ix] = dac_nxt[sq_ix];
      env_vol_nxt[sq_ix] = env_reg[7:4];
      env_per_nxt[sq_ix] = env_reg[2:0];
      env_tmr_nxt[sq_ix] = (env_reg[2:0] != 3'd0) ? {1'b0, env_reg[2:0]} : 4'd8;
      env_rise_nxt[sq_ix] = env_reg[3];
      if (!sc) begin
        sw_reg = raw_nxt[IX_NR10];
        sw_sh_nxt = f_sq;
        sw_per_nxt = sw_reg[6:4];
        sw_shift_nxt = sw_reg[2:0];
        sw_neg_nxt = sw_reg[3];
        sw_tmr_nxt = (sw_reg[6:4] != 3'd0) ? {1'b0, sw_reg[6:4]} : 4'd8;
        sw_act_nxt = (sw_reg[6:4] != 3'd0) || (sw_reg[2:0] != 3'd0);
        if (sw_reg[2:0] != 3'd0) begin
          swc = sweep_calc(f_sq, sw_reg[2:0], sw_reg[3]);
          if (swc[11]) on_nxt[0] = 1'b0;
        end
      end
    end

    if (trig_wave) begin
      if (len_nxt[2] == 9'd0) len_nxt[2] = 9'd256;
      pt_nxt[2] = wave_period(freq_nxt[2]);
      pos_nxt[2] = '0;
      on_nxt[2] = dac_nxt[2];
    end

    if (trig_noise) begin
      env_reg = raw_nxt[IX_NR42];
      if (len_nxt[3] == 9'd0) len_nxt[3] = 9'd64;
      pt_nxt[3] = noise_period(raw_nxt[IX_NR43]);
      lfsr_nxt = LFSR_SEED;
      on_nxt[3] = dac_nxt[3];
      env_vol_nxt[2] = env_reg[7:4];
      env_per_nxt[2] = env_reg[2:0];
      env_tmr_nxt[2] = (env_reg[2:0] != 3'd0) ? {1'b0, env_reg[2:0]} : 4'd8;
      env_rise_nxt[2] = env_reg[3];
    end

    // frame sequencer: a tick is shorter than a sequencer period, so one step at most
    if (tick_i) begin
      cyc_nxt = cyc_i; rem_nxt = cyc_i; ch_nxt = 2'd0; st_nxt = ST_TIMER;
      cnt_sum = {1'b0, seq_cnt_r} + {{(SEQ_W+1-CYC_W){1'b0}}, cyc_i};
      if (cnt_sum >= (SEQ_W+1)'(SEQ_PERIOD)) begin
        seq_cnt_nxt = SEQ_W'(cnt_sum - (SEQ_W+1)'(SEQ_PERIOD));
        step_nxt = step_r + 3'd1;
        if (!step_nxt[0]) begin
          for (int c = 0; c < 4; c++) begin
            if (armed_r[c] && len_r[c] != 9'd0) begin
              len_nxt[c] = len_r[c] - 9'd1;
              if (len_nxt[c] == 9'd0) on_nxt[c] = 1'b0;
            end
          end
        end
        if ((step_nxt == 3'd2 || step_nxt == 3'd6) && sw_act_r) begin
          if (sw_tmr_r != 4'd0) sw_tmr_nxt = sw_tmr_r - 4'd1;
          if (sw_tmr_nxt == 4'd0) begin
            sw_tmr_nxt = (sw_per_r != 3'd0) ? {1'b0, sw_per_r} : 4'd8;
            if (sw_per_r != 3'd0) begin
              swc = sweep_calc(sw_sh_r, sw_shift_r, sw_neg_r);
              if (swc[11]) begin
                on_nxt[0] = 1'b0;
              end else if (sw_shift_r != 3'd0) begin
                sw_sh_nxt = swc[10:0];
                freq_nxt[0] = swc[10:0];
                swc = sweep_calc(sw_sh_nxt, sw_shift_r, sw_neg_r);
                if (swc[11]) on_nxt[0] = 1'b0;
              end
            end
          end
        end
        if (step_nxt == 3'd7) begin
          for (int e = 0; e < 3; e++) begin
            if (on_nxt[(e == 2) ? 3 : e] && env_per_r[e] != 3'd0) begin
              if (env_tmr_r[e] != 4'd0) env_tmr_nxt[e] = env_tmr_r[e] - 4'd1;
              if (env_tmr_nxt[e] == 4'd0) begin
                env_tmr_nxt[e] = {1'b0, env_per_r[e]};
                if (env_rise_r[e]) begin
                  if (env_vol_r[e] != 4'd15) env_vol_nxt[e] = env_vol_r[e] + 4'd1;
                end else if (env_vol_r[e] != 4'd0) begin
                  env_vol_nxt[e] = env_vol_r[e] - 4'd1;
                end
              end
            end
          end
        end
      end else begin
        seq_cnt_nxt = cnt_sum[SEQ_W-1:0];
      end
    end

    // shared timer stepper: one wrap per cycle, then on to the next channel
    if (st_r == ST_TIMER) begin
      unique case (ch_r)
        2'd0:    per_c = sq_period(freq_r[0]);
        2'd1:    per_c = sq_period(freq_r[1]);
        2'd2:    per_c = wave_period(freq_r[2]);
        default: per_c = noise_period(raw_r[IX_NR43]);
      endcase
      pte = (pt_r[ch_r] == '0) ? per_c : pt_r[ch_r];
      if (on_r[ch_r] && ({{(PT_W-CYC_W){1'b0}}, rem_r} >= pte)) begin
        rem_nxt = rem_r - pte[CYC_W-1:0];
        pt_nxt[ch_r] = per_c;
        unique case (ch_r)
          2'd0:    pos_nxt[0] = {2'b00, pos_r[0][2:0] + 3'd1};
          2'd1:    pos_nxt[1] = {2'b00, pos_r[1][2:0] + 3'd1};
          2'd2:    pos_nxt[2] = pos_r[2] + 5'd1;
          default: begin
            fb = lfsr_r[0] ^ lfsr_r[1];
            lfsr_nxt = {fb, lfsr_r[14:1]};
            if (raw_r[IX_NR43][3]) lfsr_nxt[6] = fb;
          end
        endcase
      end else begin
        if (on_r[ch_r]) pt_nxt[ch_r] = pte - {{(PT_W-CYC_W){1'b0}}, rem_r};
        rem_nxt = cyc_r;
        ch_nxt = ch_r + 2'd1;
        if (ch_r == 2'd3) st_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ch_r <= '0; cyc_r <= '0; rem_r <= '0;
      raw_r <= '{default: '0}; wave_r <= '{default: '0}; power_r <= 1'b0;
      seq_cnt_r <= '0; step_r <= '0; on_r <= '0; dac_r <= '0; armed_r <= '0;
      len_r <= '{default: '0}; env_vol_r <= '{default: '0};
      env_per_r <= '{default: '0}; env_tmr_r <= '{default: '0}; env_rise_r <= '0;
      pt_r <= '{default: '0}; pos_r <= '{default: '0}; freq_r <= '{default: '0};
      sw_sh_r <= '0; sw_tmr_r <= '0; sw_per_r <= '0; sw_shift_r <= '0;
      sw_neg_r <= 1'b0; sw_act_r <= 1'b0; lfsr_r <= LFSR_SEED;
    end else begin
      st_r <= st_nxt; ch_r <= ch_nxt; cyc_r <= cyc_nxt; rem_r <= rem_nxt;
      raw_r <= raw_nxt; wave_r <= wave_nxt; power_r <= power_nxt;
      seq_cnt_r <= seq_cnt_nxt; step_r <= step_nxt; on_r <= on_nxt; dac_r <= dac_nxt;
      armed_r <= armed_nxt; len_r <= len_nxt; env_vol_r <= env_vol_nxt;
      env_per_r <= env_per_nxt; env_tmr_r <= env_tmr_nxt; env_rise_r <= env_rise_nxt;
      pt_r <= pt_nxt; pos_r <= pos_nxt; freq_r <= freq_nxt;
      sw_sh_r <= sw_sh_nxt; sw_tmr_r <= sw_tmr_nxt; sw_per_r <= sw_per_nxt;
      sw_shift_r <= sw_shift_nxt; sw_neg_r <= sw_neg_nxt; sw_act_r <= sw_act_nxt;
      lfsr_r <= lfsr_nxt;
    end
  end

  // channel levels, in sixtieths
  logic signed [7:0] lev [4];
  logic [7:0]        sq_mag [2];
  logic [7:0]        nz_mag;
  logic [7:0]        wbyte;
  logic [3:0]        wsamp;
  logic signed [5:0] wbase;
  logic signed [8:0] ls, rs;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      sq_mag[c] = {2'b00, env_vol_r[c], 2'b00};
      if (!on_r[c] || !dac_r[c] || env_vol_r[c] == 4'd0)
        lev[c] = '0;
      else if (DUTY_ROWS[raw_r[(c == 0) ? IX_NR11 : IX_NR21][7:6]][pos_r[c][2:0]])
        lev[c] = signed'(sq_mag[c]);
      else
        lev[c] = -signed'(sq_mag[c]);
    end
    wbyte = wave_r[pos_r[2][4:1]];
    wsamp = pos_r[2][0] ? wbyte[3:0] : wbyte[7:4];
    wbase = signed'({1'b0, wsamp, 1'b0}) - 6'sd15;
    if (!on_r[2] || !dac_r[2]) begin
      lev[2] = '0;
    end else begin
      case (raw_r[IX_NR32][6:5])
        2'd1:    lev[2] = 8'(wbase) <<< 2;
        2'd2:    lev[2] = 8'(wbase) <<< 1;
        2'd3:    lev[2] = 8'(wbase);
        default: lev[2] = '0;
      endcase
    end
    nz_mag = {2'b00, env_vol_r[2], 2'b00};
    if (!on_r[3] || !dac_r[3] || env_vol_r[2] == 4'd0) lev[3] = '0;
    else if (lfsr_r[0]) lev[3] = -signed'(nz_mag);
    else lev[3] = signed'(nz_mag);
    ls = '0;
    rs = '0;
    for (int c = 0; c < 4; c++) begin
      if (raw_r[IX_NR51][4+c]) ls = ls + 9'(lev[c]);
      if (raw_r[IX_NR51][c])   rs = rs + 9'(lev[c]);
    end
  end

  assign mix_o.power = power_r;
  assign mix_o.lsum  = ls;
  assign mix_o.rsum  = rs;
  assign mix_o.lvol  = {1'b0, raw_r[IX_NR50][6:4]} + 4'd1;
  assign mix_o.rvol  = {1'b0, raw_r[IX_NR50][2:0]} + 4'd1;
  assign busy_o      = (st_r == ST_TIMER);

endmodule

### rtl/core/fcsg_filt.sv
// ----------------------------------------------------------------------------
// fcsg_filt - gain and high-pass unit
// One side per run over a single shared 16x24 multiplier: gain scaling
// with rounding, the feedback product in two halves, then the output
// rounding and saturation. Holds the filter history of both sides.
// ----------------------------------------------------------------------------
module fcsg_filt import fcsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr_i,
  input  logic               start_i,
  input  logic               side_i,
  input  logic signed [8:0]  sum_i,
  input  logic [3:0]         vol_i,
  output logic               done_o,
  output logic signed [15:0] sample_o
);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_A    = 8'b0000_0010,
    F_B    = 8'b0000_0100,
    F_Q    = 8'b0000_1000,
    F_LO   = 8'b0001_0000,
    F_HI   = 8'b0010_0000,
    F_RND  = 8'b0100_0000,
    F_OUT  = 8'b1000_0000
  } fst_t;

  fst_t               st_r, st_nxt;
  logic               side_r, neg_r, done_r;
  logic [10:0]        mag_r;
  logic [23:0]        a_r;
  logic signed [24:0] x_r;
  logic [39:0]        prod_r, plo_r;
  logic [31:0]        r_r;
  logic signed [24:0] xp_r [2];
  logic signed [31:0] yp_r [2];
  logic signed [15:0] sample_r;

  logic [15:0]        mul_a;
  logic [23:0]        mul_b;
  logic signed [13:0] n_in;
  logic [31:0]        ymag;
  logic [13:0]        t_div;
  logic [23:0]        sumx;
  logic [55:0]        pfull;
  logic signed [33:0] y_full;
  logic signed [31:0] y_sat;
  logic [31:0]        yo_mag;
  logic [22:0]        o_mag;
  logic signed [15:0] o_val;

  assign n_in  = sum_i * signed'({1'b0, vol_i});
  assign ymag  = yp_r[side_r][31] ? (32'd0 - 32'(yp_r[side_r])) : 32'(yp_r[side_r]);
  assign t_div = 14'((prod_r[18:0] + 19'd240) >> 5);
  assign sumx  = a_r + {13'b0, prod_r[32:22]};
  assign pfull = {prod_r, 16'b0} + {16'b0, plo_r} + 56'h80_0000;

  always_comb begin
    y_full = 34'(x_r) - 34'(xp_r[side_r])
           + (yp_r[side_r][31] ? -34'(signed'({1'b0, r_r})) : 34'(signed'({1'b0, r_r})));
    if (y_full > 34'sh0_7FFF_FFFF) y_sat = 32'sh7FFF_FFFF;
    else if (y_full < -34'sh0_8000_0000) y_sat = 32'sh8000_0000;
    else y_sat = 32'(y_full);
    yo_mag = y_sat[31] ? (32'd0 - 32'(y_sat)) : 32'(y_sat);
    o_mag  = 23'((33'(yo_mag) + 33'd256) >> 9);
    if (!y_sat[31]) o_val = (o_mag > 23'd32767) ? 16'sh7FFF : 16'(o_mag);
    else o_val = (o_mag > 23'd32768) ? 16'sh8000 : -16'(o_mag);
  end

  always_comb begin
    st_nxt = st_r;
    mul_a  = {5'b0, mag_r};
    mul_b  = GAIN_INT;
    unique case (st_r)
      F_IDLE: if (start_i) st_nxt = F_A;
      F_A:    st_nxt = F_B;
      F_B:    begin mul_b = GAIN_FRAC; st_nxt = F_Q; end
      F_Q:    begin mul_a = {2'b0, t_div}; mul_b = RECIP_15; st_nxt = F_LO; end
      F_LO:   begin mul_a = ymag[15:0]; mul_b = HP_COEF; st_nxt = F_HI; end
      F_HI:   begin mul_a = ymag[31:16]; mul_b = HP_COEF; st_nxt = F_RND; end
      F_RND:  st_nxt = F_OUT;
      F_OUT:  st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (st_r == F_IDLE && start_i) begin
      side_r <= side_i;
      neg_r  <= n_in[13];
      mag_r  <= n_in[13] ? 11'(-n_in) : 11'(n_in);
    end
    if (st_r == F_B) a_r <= prod_r[23:0];
    if (st_r == F_LO) x_r <= neg_r ? -25'(sumx) : 25'(sumx);
    if (st_r == F_HI) plo_r <= prod_r;
    if (st_r == F_RND) r_r <= pfull[55:24];
    if (st_r == F_OUT) sample_r <= o_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
      xp_r   <= '{default: '0};
      yp_r   <= '{default: '0};
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == F_OUT);
      if (clr_i) begin
        xp_r <= '{default: '0};
        yp_r <= '{default: '0};
      end else if (st_r == F_OUT) begin
        xp_r[side_r] <= x_r;
        yp_r[side_r] <= y_sat;
      end
    end
  end

  assign done_o   = done_r;
  assign sample_o = sample_r;

endmodule

### rtl/core/four_channel_sound_generator.sv
// ----------------------------------------------------------------------------
// four_channel_sound_generator - four-voice sound generator
// Takes register-write and time-advance words, produces filtered stereo
// sample words.
//
// Input channel: in_tuser = 0 writes in_tdata byte to the sound register page,
// in_tuser = 1 advances time by the cycle count. While powered, an advance
// steps the frame sequencer, then the shared timer stepper visits each
// channel and each period wrap, and each of up to three emitted samples has
// its left and right sides passed through the shared multiplier before
// hand-over; while powered off the samples are zero. in_tready is high only
// while the block is idle. Output channel: one word per sample, out_tlast on
// the last sample of an advance. A single output register holds a finished
// word while the next input is accepted; if the receiver stalls the next
// sample waits in the pending registers and the sequencer holds.
// Reset clears the page, the wave table and all channel state; the noise
// register seeds to all ones and the sample rate returns to 48000.
// cfg_we/cfg_wdata set the output sample rate; the user must write it only
// while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module four_channel_sound_generator import fcsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_addr[5:0], write_data[13:6], cycle_count[22:14]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // left_sample[15:0], right_sample[31:16]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  typedef enum logic [5:0] {
    T_IDLE  = 6'b00_0001,
    T_CHAN  = 6'b00_0010,
    T_LEFT  = 6'b00_0100,
    T_WAITL = 6'b00_1000,
    T_WAITR = 6'b01_0000,
    T_PUSH  = 6'b10_0000
  } tst_t;

  tst_t               st_r, st_nxt;
  logic [RATE_W-1:0]  rate_r;
  logic [CLK_LOG2-1:0] racc_r;
  logic [1:0]         nsmp_r;
  logic signed [15:0] pend_l_r, pend_r_r;
  logic               out_valid_r, out_last_r;
  logic [31:0]        out_data_r;

  logic               accept, wr, tick, adv;
  logic [CYC_W-1:0]   cc, cyc;
  logic [ACC_W-1:0]   acc;
  logic [3:0]         due;
  logic               chan_busy;
  mix_t               mix;
  logic               filt_start, filt_side, filt_done, filt_clr;
  logic signed [15:0] filt_sample;
  logic               push_ok;

  assign in_tready = (st_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cc        = in_tdata[22:14];
  assign cyc       = (cc > CYC_W'(MAX_TICK)) ? CYC_W'(MAX_TICK) : cc;
  assign wr        = accept && !in_tuser;
  assign adv       = accept && in_tuser && (cyc != '0);
  assign tick      = adv && mix.power;
  assign filt_clr  = wr && (in_tdata[5:0] == ADDR_POWER) && (in_tdata[13] != mix.power);
  assign acc       = ACC_W'(racc_r) + ACC_W'(cyc) * ACC_W'(rate_r);
  assign due       = acc[ACC_W-1:CLK_LOG2];
  assign push_ok   = !out_valid_r || out_tready;

  assign filt_side  = (st_r == T_WAITL);
  assign filt_start = (st_r == T_LEFT && mix.power) || (st_r == T_WAITL && filt_done);

  fcsg_chan u_chan (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (wr),
    .addr_i (in_tdata[5:0]),
    .data_i (in_tdata[13:6]),
    .tick_i (tick),
    .cyc_i  (cyc),
    .busy_o (chan_busy),
    .mix_o  (mix)
  );

  fcsg_filt u_filt (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_i    (filt_clr),
    .start_i  (filt_start),
    .side_i   (filt_side),
    .sum_i    (filt_side ? mix.rsum : mix.lsum),
    .vol_i    (filt_side ? mix.rvol : mix.lvol),
    .done_o   (filt_done),
    .sample_o (filt_sample)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE:  if (adv) st_nxt = T_CHAN;
      T_CHAN:  if (!chan_busy) st_nxt = (nsmp_r == 2'd0) ? T_IDLE : T_LEFT;
      T_LEFT:  st_nxt = mix.power ? T_WAITL : T_PUSH;
      T_WAITL: if (filt_done) st_nxt = T_WAITR;
      T_WAITR: if (filt_done) st_nxt = T_PUSH;
      T_PUSH:  if (push_ok) st_nxt = (nsmp_r == 2'd1) ? T_IDLE : T_LEFT;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == T_LEFT && !mix.power) begin
      pend_l_r <= '0;
      pend_r_r <= '0;
    end
    if (st_r == T_WAITL && filt_done) pend_l_r <= filt_sample;
    if (st_r == T_WAITR && filt_done) pend_r_r <= filt_sample;
    if (st_r == T_PUSH && push_ok) begin
      out_data_r <= {pend_r_r, pend_l_r};
      out_last_r <= (nsmp_r == 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      rate_r      <= RATE_W'(RATE_RESET);
      racc_r      <= '0;
      nsmp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) rate_r <= cfg_wdata;
      if (adv) begin
        // surplus whole samples are dropped, only the fraction is kept
        racc_r <= acc[CLK_LOG2-1:0];
        nsmp_r <= (due > 4'd3) ? 2'd3 : due[1:0];
      end else if (st_r == T_PUSH && push_ok) begin
        nsmp_r <= nsmp_r - 2'd1;
      end
      if (st_r == T_PUSH && push_ok) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_idle_chan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !chan_busy)
    else $error("input taken while timer stepper busy");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    filt_done |-> (st_r == T_WAITL || st_r == T_WAITR))
    else $error("filter result outside a wait state");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_PUSH) |-> (nsmp_r != 2'd0))
    else $error("sample push with no samples due");

  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_PUSH && out_valid_r && !out_tready) |=> (st_r == T_PUSH))
    else $error("pending sample lost under stall");

endmodule

### sim/fcsg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_checker - sample predictor and scoreboard
// Watches the command, sample and rate ports of the sound generator, keeps
// its own model of the voices, sequencer, mixer and high-pass filter, and
// compares every sample word against the oldest predicted one.
// ----------------------------------------------------------------------------
module fcsg_checker import fcsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  output int          fails,
  output int          waiting,
  output int          samples
);

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } sample_t;

  localparam int unsigned CLOCK_HZ = 4194304;
  localparam bit [7:0] DUTY_PAT [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};
  localparam int unsigned NOISE_BASE [8] = '{8, 16, 32, 48, 64, 80, 96, 112};

  sample_t sample_q[$];

  logic [16:0]  rate;
  logic [7:0]   page [22];
  logic [7:0]   wave_ram [16];
  bit           powered;
  int unsigned  resamp_acc;
  int unsigned  frame_cnt;
  logic [2:0]   frame_step;
  bit           voice_on [4];
  bit           dac_en [4];
  bit           len_en [4];
  int unsigned  len_left [4];
  int unsigned  env_vol [3];
  int unsigned  env_per [3];
  int unsigned  env_tmr [3];
  bit           env_up [3];
  int unsigned  div_tmr [4];
  int unsigned  step_pos [3];
  logic [10:0]  sw_shadow;
  int unsigned  sw_tmr, sw_per, sw_shift;
  bit           sw_neg, sw_active;
  logic [14:0]  lfsr;
  int           hp_hist [4];   // x_prev left/right, y_prev left/right
  logic [10:0]  freq [3];

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic [10:0] page_freq(int b);
    return {page[b+4][2:0], page[b+3]};
  endfunction

  function automatic int unsigned noise_len();
    return NOISE_BASE[page[IX_NR43][2:0]] << page[IX_NR43][7:4];
  endfunction

  function automatic void dac_check(int ch);
    logic [7:0] v;
    if (ch < 2)       v = page[ch*5+2] & 8'hF8;
    else if (ch == 2) v = page[IX_NR30] & 8'h80;
    else              v = page[IX_NR42] & 8'hF8;
    dac_en[ch] = (v != 0);
    if (!dac_en[ch]) voice_on[ch] = 0;
  endfunction

  function automatic void clear_voices();
    for (int c = 0; c < 4; c++) begin
      voice_on[c] = 0; dac_en[c] = 0; len_en[c] = 0; len_left[c] = 0;
      div_tmr[c] = 0; hp_hist[c] = 0;
    end
    for (int c = 0; c < 3; c++) begin
      env_vol[c] = 0; env_per[c] = 0; env_tmr[c] = 0; env_up[c] = 0;
      step_pos[c] = 0; freq[c] = 0;
    end
    sw_shadow = 0; sw_tmr = 0; sw_per = 0; sw_shift = 0; sw_neg = 0; sw_active = 0;
    lfsr = 15'h7FFF;
    frame_cnt = 0;
    frame_step = 0;
  endfunction

  function automatic void load_from_page();
    for (int c = 0; c < 2; c++) begin
      len_left[c] = 64 - page[c*5+1][5:0];
      len_en[c]   = page[c*5+4][6];
      freq[c]     = page_freq(c*5);
      dac_check(c);
    end
    len_left[2] = 256 - page[IX_NR31];
    len_en[2]   = page[IX_NR34][6];
    freq[2]     = page_freq(IX_NR30);
    dac_check(2);
    len_left[3] = 64 - page[IX_NR41][5:0];
    len_en[3]   = page[IX_NR44][6];
    dac_check(3);
  endfunction

  function automatic void env_load(int e, logic [7:0] r);
    env_vol[e] = r[7:4];
    env_per[e] = r[2:0];
    env_tmr[e] = (r[2:0] != 0) ? r[2:0] : 8;
    env_up[e]  = r[3];
  endfunction

  function automatic logic [10:0] sweep_next(output bit over);
    int unsigned d, nx;
    d  = sw_shadow >> sw_shift;
    nx = sw_neg ? sw_shadow - d : sw_shadow + d;
    over = (nx > 2047);
    return over ? sw_shadow : nx[10:0];
  endfunction

  function automatic void trigger_square(int c);
    bit ov;
    freq[c] = page_freq(c*5);
    if (len_left[c] == 0) len_left[c] = 64;
    div_tmr[c]  = (2048 - freq[c]) * 4;
    step_pos[c] = 0;
    voice_on[c] = dac_en[c];
    env_load(c, page[c*5+2]);
    if (c == 0) begin
      sw_shadow = freq[0];
      sw_per    = page[IX_NR10][6:4];
      sw_shift  = page[IX_NR10][2:0];
      sw_neg    = page[IX_NR10][3];
      sw_tmr    = (sw_per != 0) ? sw_per : 8;
      sw_active = (sw_per != 0) || (sw_shift != 0);
      if (sw_shift != 0) begin
        void'(sweep_next(ov));
        if (ov) voice_on[0] = 0;
      end
    end
  endfunction

  function automatic void reg_write(logic [4:0] idx, logic [7:0] v);
    int c;
    c = (idx >= IX_NR21) ? 1 : 0;
    case (idx)
      IX_NR10: begin
        sw_per = v[6:4]; sw_shift = v[2:0]; sw_neg = v[3];
      end
      IX_NR11, IX_NR21: len_left[c] = 64 - v[5:0];
      IX_NR12, IX_NR22: dac_check(c);
      IX_NR13, IX_NR23: freq[c] = page_freq(c*5);
      IX_NR14, IX_NR24: begin
        len_en[c] = v[6];
        freq[c] = page_freq(c*5);
        if (v[7]) trigger_square(c);
      end
      IX_NR30: dac_check(2);
      IX_NR31: len_left[2] = 256 - v;
      IX_NR33: freq[2] = page_freq(IX_NR30);
      IX_NR34: begin
        len_en[2] = v[6];
        freq[2] = page_freq(IX_NR30);
        if (v[7]) begin
          if (len_left[2] == 0) len_left[2] = 256;
          div_tmr[2]  = (2048 - freq[2]) * 2;
          step_pos[2] = 0;
          voice_on[2] = dac_en[2];
        end
      end
      IX_NR41: len_left[3] = 64 - v[5:0];
      IX_NR42: dac_check(3);
      IX_NR44: begin
        len_en[3] = v[6];
        if (v[7]) begin
          if (len_left[3] == 0) len_left[3] = 64;
          div_tmr[3]  = noise_len();
          lfsr        = 15'h7FFF;
          voice_on[3] = dac_en[3];
          env_load(2, page[IX_NR42]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void env_clock(int ch, int e);
    if (!voice_on[ch] || env_per[e] == 0) return;
    if (env_tmr[e] > 0) env_tmr[e]--;
    if (env_tmr[e] == 0) begin
      env_tmr[e] = env_per[e];
      if (env_up[e]) begin
        if (env_vol[e] < 15) env_vol[e]++;
      end else if (env_vol[e] > 0) env_vol[e]--;
    end
  endfunction

  function automatic void sweep_clock();
    bit ov;
    logic [10:0] nx;
    if (!sw_active) return;
    if (sw_tmr > 0) sw_tmr--;
    if (sw_tmr != 0) return;
    sw_tmr = (sw_per != 0) ? sw_per : 8;
    if (sw_per == 0) return;
    nx = sweep_next(ov);
    if (ov) begin
      voice_on[0] = 0;
      return;
    end
    if (sw_shift != 0) begin
      sw_shadow = nx;
      freq[0] = nx;
      void'(sweep_next(ov));
      if (ov) voice_on[0] = 0;
    end
  endfunction

  function automatic void frame_advance(int unsigned cyc);
    frame_cnt += cyc;
    while (frame_cnt >= SEQ_PERIOD) begin
      frame_cnt -= SEQ_PERIOD;
      frame_step++;
      if (!frame_step[0]) begin
        for (int c = 0; c < 4; c++)
          if (len_en[c] && len_left[c] > 0) begin
            len_left[c]--;
            if (len_left[c] == 0) voice_on[c] = 0;
          end
      end
      if (frame_step == 2 || frame_step == 6) sweep_clock();
      if (frame_step == 7) begin
        env_clock(0, 0);
        env_clock(1, 1);
        env_clock(3, 2);
      end
    end
  endfunction

  function automatic int unsigned divider_run(int ch, int unsigned cyc, int unsigned per);
    int unsigned wraps;
    wraps = 0;
    if (div_tmr[ch] == 0) div_tmr[ch] = per;
    while (cyc >= div_tmr[ch]) begin
      cyc -= div_tmr[ch];
      div_tmr[ch] = per;
      wraps++;
    end
    div_tmr[ch] -= cyc;
    return wraps;
  endfunction

  function automatic void voices_run(int unsigned cyc);
    int unsigned w;
    bit fb;
    for (int c = 0; c < 2; c++)
      if (voice_on[c]) begin
        w = divider_run(c, cyc, (2048 - freq[c]) * 4);
        step_pos[c] = (step_pos[c] + w) & 7;
      end
    if (voice_on[2] && dac_en[2]) begin
      w = divider_run(2, cyc, (2048 - freq[2]) * 2);
      step_pos[2] = (step_pos[2] + w) & 31;
    end
    if (voice_on[3] && dac_en[3]) begin
      w = divider_run(3, cyc, noise_len());
      repeat (w) begin
        fb = lfsr[0] ^ lfsr[1];
        lfsr = {fb, lfsr[14:1]};
        if (page[IX_NR43][3]) lfsr[6] = fb;
      end
    end
  endfunction

  function automatic int voice_level(int c);
    int vol;
    logic [7:0] b;
    logic [3:0] s;
    int code;
    if (!voice_on[c] || !dac_en[c]) return 0;
    if (c < 2) begin
      vol = env_vol[c];
      if (vol == 0) return 0;
      return DUTY_PAT[page[c*5+1][7:6]][step_pos[c]] ? 4 * vol : -4 * vol;
    end
    if (c == 2) begin
      code = page[IX_NR32][6:5];
      if (code == 0) return 0;
      b = wave_ram[step_pos[2] >> 1];
      s = step_pos[2][0] ? b[3:0] : b[7:4];
      return (2 * int'(s) - 15) * (1 << (3 - code));
    end
    vol = env_vol[2];
    if (vol == 0) return 0;
    return lfsr[0] ? -4 * vol : 4 * vol;
  endfunction

  function automatic logic signed [15:0] highpass(int side, int sum, int vol);
    longint x, y, o;
    x = round_div(longint'(sum) * vol * 3690988, 480);
    y = x - hp_hist[side] + round_div(longint'(hp_hist[2+side]) * 16710107, 16777216);
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    hp_hist[side]   = int'(x);
    hp_hist[2+side] = int'(y);
    o = round_div(y, 512);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[15:0];
  endfunction

  function automatic sample_t mix_sample();
    sample_t s;
    int lv, ls, rs;
    s.last = 0;
    if (!powered) begin
      s.left = 0;
      s.right = 0;
      return s;
    end
    ls = 0;
    rs = 0;
    for (int c = 0; c < 4; c++) begin
      lv = voice_level(c);
      if (page[IX_NR51][4+c]) ls += lv;
      if (page[IX_NR51][c])   rs += lv;
    end
    s.left  = highpass(0, ls, page[IX_NR50][6:4] + 1);
    s.right = highpass(1, rs, page[IX_NR50][2:0] + 1);
    return s;
  endfunction

  function automatic void accept_word(logic cmd, logic [23:0] d);
    logic [5:0] addr;
    logic [7:0] v;
    int unsigned cyc, n;
    longint unsigned acc;
    sample_t s;
    addr = d[5:0];
    v    = d[13:6];
    cyc  = d[22:14];
    if (!cmd) begin
      if (addr == ADDR_POWER) begin
        if (v[7] && !powered) begin
          clear_voices();
          powered = 1;
          load_from_page();
        end else if (!v[7] && powered) begin
          clear_voices();
          powered = 0;
        end
      end else if (addr >= ADDR_WAVE) begin
        wave_ram[addr - ADDR_WAVE] = v;
      end else if (addr >= ADDR_REG_LO && addr <= ADDR_REG_HI) begin
        page[addr - ADDR_REG_LO] = v;
        if (powered) reg_write(5'(addr - ADDR_REG_LO), v);
      end
      return;
    end
    if (cyc > MAX_TICK) cyc = MAX_TICK;
    if (cyc == 0) return;
    if (powered) begin
      frame_advance(cyc);
      voices_run(cyc);
    end
    acc = longint'(resamp_acc) + longint'(cyc) * rate;
    n = 0;
    while (acc >= CLOCK_HZ && n < 3) begin
      acc -= CLOCK_HZ;
      s = mix_sample();
      sample_q.push_back(s);
      n++;
    end
    resamp_acc = acc % CLOCK_HZ;
    if (n > 0) sample_q[$].last = 1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: sample %0d %s mismatch: got %0d, expected %0d",
             $realtime, samples, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      rate = RATE_RESET;
      for (int i = 0; i < 22; i++) page[i] = 0;
      for (int i = 0; i < 16; i++) wave_ram[i] = 0;
      powered = 0;
      resamp_acc = 0;
      clear_voices();
      sample_q.delete();
      fails = 0;
      samples = 0;
    end else begin
      if (cfg_we) rate = cfg_wdata;
      if (in_tvalid && in_tready) accept_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (sample_q.size() == 0) begin
          // word count: one arrived, none predicted
          report_mismatch("word count", 1, 0);
        end else begin
          want = sample_q.pop_front();
          if ($signed(out_tdata[15:0]) != want.left)
            report_mismatch("left", $signed(out_tdata[15:0]), want.left);
          if ($signed(out_tdata[31:16]) != want.right)
            report_mismatch("right", $signed(out_tdata[31:16]), want.right);
          if (out_tlast != want.last)
            report_mismatch("last", out_tlast, want.last);
        end
        samples++;
      end
    end
    waiting = sample_q.size();
  end

endmodule

### sim/tb_four_channel_sound_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_channel_sound_generator - testbench top
// Drives register writes and time advances into the sound generator over
// several sample rates and back-pressure patterns; the checker predicts and
// compares every sample word.
// ----------------------------------------------------------------------------
module tb_four_channel_sound_generator;
  import fcsg_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = 0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 0;
  logic [16:0] cfg_wdata = 0;

  int fails, waiting, samples;
  int send_idle = 0;
  int recv_stall = 0;
  int words_sent = 0;
  logic hold_go = 0;
  bit   hold_done = 0;
  int   hold_left = 0;

  four_channel_sound_generator dut (.*);

  fcsg_checker chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // long receiver hold-off, counted here, so the block backs up
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1;
      hold_left <= 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  task automatic send_word(logic cmd, logic [5:0] addr, logic [7:0] data, logic [8:0] cyc);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, cyc, data, addr};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic wr(logic [5:0] addr, logic [7:0] data);
    send_word(1'b0, addr, data, 9'($urandom));
  endtask

  task automatic adv(logic [8:0] cyc);
    send_word(1'b1, 6'($urandom), 8'($urandom), cyc);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    // an advance may still be running with no sample due
    repeat (600) @(posedge clk);
  endtask

  task automatic set_rate(logic [16:0] r);
    cfg_we <= 1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_words(int n);
    int k, r;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 40) begin
        r = $urandom_range(99);
        if (r < 4)       adv(0);
        else if (r < 10) adv(9'($urandom_range(257, 511)));
        else             adv(9'($urandom_range(1, 256)));
      end else if (k < 80) begin
        wr(6'($urandom_range(16, 37)), 8'($urandom));
      end else if (k < 88) begin
        wr(6'($urandom_range(48, 63)), 8'($urandom));
      end else if (k < 93) begin
        wr(ADDR_POWER, ($urandom_range(99) < 75) ? (8'($urandom) | 8'h80)
                                                 : (8'($urandom) & 8'h7F));
      end else begin
        wr(6'($urandom_range(0, 63)), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: an ignored offset, empty advance, power up, all four voices
    wr(6'h05, 8'hAA);
    adv(9'd0);
    wr(ADDR_POWER, 8'h80);
    wr(6'h24, 8'h77);
    wr(6'h25, 8'hFF);
    wr(6'h11, 8'hBF);
    wr(6'h12, 8'hF3);
    wr(6'h10, 8'h7F);
    wr(6'h13, 8'hFF);
    wr(6'h14, 8'hC7);
    wr(6'h16, 8'hC0);
    wr(6'h17, 8'h0F);
    wr(6'h19, 8'h87);
    wr(6'h1A, 8'h80);
    wr(6'h30, 8'hF0);
    wr(6'h3F, 8'h0F);
    wr(6'h1C, 8'h20);
    wr(6'h1E, 8'hC7);
    wr(6'h20, 8'h3F);
    wr(6'h21, 8'hF1);
    wr(6'h22, 8'hFF);   // largest shift, short LFSR
    wr(6'h23, 8'hC0);
    adv(9'd511);        // saturates to the tick limit
    adv(9'd256);
    adv(9'd1);
    drain();

    // free flow, with a long receiver hold-off at the top rate
    set_rate(17'd96000);
    send_idle = 0;
    recv_stall = 0;
    hold_go <= 1;
    random_words(28);
    drain();

    set_rate(17'd8000);
    send_idle = 84;
    random_words(28);
    drain();

    set_rate(17'($urandom_range(8000, 96000)));
    send_idle = 0;
    recv_stall = 84;
    random_words(28);
    drain();

    set_rate(17'd48000);
    send_idle = 10;
    recv_stall = 10;
    random_words(28);
    drain();

    $display("Sent %0d command words over five rate settings and four flow patterns;",
             words_sent);
    $display("%0d sample words compared, %0d mismatches.", samples, fails);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/fcsg_pkg.sv
rtl/core/fcsg_chan.sv
rtl/core/fcsg_filt.sv
rtl/core/four_channel_sound_generator.sv
sim/fcsg_checker.sv
sim/tb_four_channel_sound_generator.sv
